[sv/dcrc_pkg.sv]
`default_nettype none

package dcrc_pkg;

	localparam int CRC_W     = 64;
	localparam int CNT_W     = 5;
	localparam int LANE_BYTES = 16;
	localparam int WIN_BYTES = 16;
	localparam int WIN_W     = 8 * WIN_BYTES;
	localparam int ADV_BYTES = 1 << (CNT_W - 1);

	localparam logic [CRC_W-1:0] POLY32 = 64'h0000_0000_EDB8_8320;
	localparam logic [CRC_W-1:0] POLY64 = 64'hC96C_5795_D787_0F42;

	localparam logic MODE_CRC32 = 1'b0;
	localparam logic MODE_CRC64 = 1'b1;

	typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;
	typedef logic [1:0][CNT_W-1:0][CRC_W-1:0][CRC_W-1:0] adv_tab_t;
	typedef logic [1:0][WIN_W-1:0][CRC_W-1:0] data_tab_t;

	typedef struct packed {
		logic [CRC_W-1:0] dcrc;
		logic [CNT_W-1:0] cnt;
		logic             start;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

	function automatic logic [CRC_W-1:0] bit_step(logic [CRC_W-1:0] r, logic [CRC_W-1:0] poly);
		return (r >> 1) ^ (r[0] ? poly : '0);
	endfunction

	// columns of the zero-byte advance by 1, 2, 4, 8, 16 bytes
	function automatic adv_tab_t build_adv();
		adv_tab_t t;
		logic [CRC_W-1:0] r;
		logic [CRC_W-1:0] poly;
		t = '0;
		for (int m = 0; m < 2; m++) begin
			poly = (m == 1) ? POLY64 : POLY32;
			for (int j = 0; j < CRC_W; j++) begin
				r = '0;
				r[j] = 1'b1;
				for (int s = 1; s <= ADV_BYTES; s++) begin
					for (int b = 0; b < 8; b++) begin
						r = bit_step(r, poly);
					end
					for (int k = 0; k < CNT_W; k++) begin
						if (s == (1 << k)) begin
							t[m][k][j] = r;
						end
					end
				end
			end
		end
		return t;
	endfunction

	// columns of the CRC of a right-aligned window, zero start
	function automatic data_tab_t build_data();
		data_tab_t t;
		logic [CRC_W-1:0] r;
		logic [CRC_W-1:0] poly;
		t = '0;
		for (int m = 0; m < 2; m++) begin
			poly = (m == 1) ? POLY64 : POLY32;
			for (int b = 0; b < 8; b++) begin
				r = '0;
				r[b] = 1'b1;
				for (int s = 1; s <= WIN_BYTES; s++) begin
					for (int k = 0; k < 8; k++) begin
						r = bit_step(r, poly);
					end
					t[m][8 * (WIN_BYTES - s) + b] = r;
				end
			end
		end
		return t;
	endfunction

	localparam adv_tab_t  ADV_TAB  = build_adv();
	localparam data_tab_t DATA_TAB = build_data();

	function automatic logic [CRC_W-1:0] mat_apply(mat_t cols, logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] res;
		res = '0;
		for (int j = 0; j < CRC_W; j++) begin
			res = res ^ (v[j] ? cols[j] : '0);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[sv/dcrc_front.sv]
`default_nettype none

module dcrc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [63:0]                data_low,
	input  wire logic [63:0]                data_high,
	input  wire logic [4:0]                 byte_count,
	input  wire logic                       start_message,
	input  wire logic                       crc_mode,
	input  wire dcrc_pkg::q_stat_t          q_stat,
	output logic                            q_push,
	output dcrc_pkg::q_entry_t              q_wdata
);

	logic                          accept;
	logic                          s1_move;
	logic                          s2_free;
	logic [dcrc_pkg::CNT_W-1:0]    cnt_sat;
	logic [dcrc_pkg::CNT_W-1:0]    shift_bytes;
	logic [dcrc_pkg::WIN_W-1:0]    win;
	logic [dcrc_pkg::CRC_W-1:0]    dcrc;

	logic                          valid_s1;
	logic [dcrc_pkg::WIN_W-1:0]    win_s1;
	logic [dcrc_pkg::CNT_W-1:0]    cnt_s1;
	logic                          start_s1;

	logic                          valid_s2;
	logic [dcrc_pkg::CRC_W-1:0]    dcrc_s2;
	logic [dcrc_pkg::CNT_W-1:0]    cnt_s2;
	logic                          start_s2;

	// handshake chain back from the queue
	assign q_push   = valid_s2 && !q_stat.full;
	assign s2_free  = !valid_s2 || q_push;
	assign s1_move  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	// saturate count, then right-align valid bytes; bytes past count drop off the top
	always_comb begin
		cnt_sat = (byte_count > dcrc_pkg::CNT_W'(dcrc_pkg::LANE_BYTES)) ?
			dcrc_pkg::CNT_W'(dcrc_pkg::LANE_BYTES) : byte_count;
		shift_bytes = dcrc_pkg::CNT_W'(dcrc_pkg::WIN_BYTES) - cnt_sat;
		win = {data_high, data_low} << {shift_bytes, 3'b000};
	end

	// zero-start CRC of the window: fixed XOR network
	always_comb begin
		dcrc = '0;
		for (int q = 0; q < dcrc_pkg::WIN_W; q++) begin
			dcrc = dcrc ^ (win_s1[q] ? dcrc_pkg::DATA_TAB[crc_mode][q] : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				valid_s2 <= 1'b1;
			end else if (q_push) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1   <= win;
			cnt_s1   <= cnt_sat;
			start_s1 <= start_message;
		end
		if (s1_move) begin
			dcrc_s2  <= dcrc;
			cnt_s2   <= cnt_s1;
			start_s2 <= start_s1;
		end
	end

	assign q_wdata.dcrc  = dcrc_s2;
	assign q_wdata.cnt   = cnt_s2;
	assign q_wdata.start = start_s2;

endmodule

`default_nettype wire

[sv/dcrc_queue.sv]
`default_nettype none

module dcrc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire dcrc_pkg::q_entry_t  wdata,
	input  wire logic                pop,
	output dcrc_pkg::q_entry_t       rdata,
	output dcrc_pkg::q_stat_t        stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	dcrc_pkg::q_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rdata          = entries_q[rd_ptr_q];
	assign stat.full      = (fill_q == FILL_W'(DEPTH));
	assign stat.not_empty = (fill_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

[sv/dcrc_back.sv]
`default_nettype none

module dcrc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dcrc_pkg::q_stat_t   q_stat,
	input  wire dcrc_pkg::q_entry_t  q_rdata,
	output logic                     q_pop,
	input  wire logic                crc_mode,
	input  wire logic [63:0]         seed_value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [63:0]              crc_value
);

	logic [dcrc_pkg::CRC_W-1:0] crc_q;
	logic [dcrc_pkg::CRC_W-1:0] res_q;
	logic                       out_valid_q;
	logic [dcrc_pkg::CRC_W-1:0] base;
	logic [dcrc_pkg::CRC_W-1:0] adv [dcrc_pkg::CNT_W+1];
	logic [dcrc_pkg::CRC_W-1:0] crc_nxt;

	assign q_pop = q_stat.not_empty && (!out_valid_q || !out_stall);

	// register advanced over count zero bytes, in binary steps, then data term
	always_comb begin
		base = q_rdata.start ? ~seed_value : crc_q;
		if (crc_mode == dcrc_pkg::MODE_CRC32) begin
			base[63:32] = '0;
		end
		adv[0] = base;
		for (int k = 0; k < dcrc_pkg::CNT_W; k++) begin
			adv[k+1] = q_rdata.cnt[k] ?
				dcrc_pkg::mat_apply(dcrc_pkg::ADV_TAB[crc_mode][k], adv[k]) : adv[k];
		end
		crc_nxt = adv[dcrc_pkg::CNT_W] ^ q_rdata.dcrc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				crc_q       <= crc_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= (crc_mode == dcrc_pkg::MODE_CRC64) ? ~crc_nxt : {32'h0, ~crc_nxt[31:0]};
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = res_q;

endmodule

`default_nettype wire

[sv/dual_crc32_crc64_engine.sv]
// Dual CRC engine: reflected CRC-32 (IEEE 802.3) or reflected CRC-64 (ECMA-182).
// Input channel (in_valid / in_stall): one transfer carries up to 16 message bytes,
//   byte 0 in data_low[7:0] upward, byte 8 in data_high[7:0] upward, byte_count valid
//   bytes (above 16 treated as 16) and start_message, which reloads the register
//   from the inverted seed before the bytes are folded in.
// Output channel (out_valid / out_stall): one transfer per input transfer, the
//   finalized CRC of all bytes so far; upper 32 bits zero in CRC-32 mode.
// APB port: register 0 at 0x0 is crc_mode (0 = CRC-32, 1 = CRC-64), register 1 at 0x8
//   is seed_value (finalized CRC of preceding data). Write only while idle.
// Path: front stages s1 and s2, then the queue, then the back-end result register.
// Throughput: one transfer per cycle while out_stall is low. The loop-carried part is
//   in the back end (zero-byte advance over five binary steps plus the data term);
//   the data term is computed two stages ahead, independent of the register.
// Reset: crc register all ones, mode CRC-32, seed zero, pipeline and queue empty.
// Stall: a stalled result holds in the output register; the back end stops
//   popping, the queue (QUEUE_DEPTH entries) fills, then the front stages fill and
//   in_stall rises. Up to QUEUE_DEPTH + 3 transfers can be in flight.
`default_nettype none

module dual_crc32_crc64_engine #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_low,
	input  wire logic [63:0] data_high,
	input  wire logic [4:0]  byte_count,
	input  wire logic        start_message,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      crc_value,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SEED = 1'b1;

	logic               crc_mode_q;
	logic [63:0]        seed_value_q;
	logic               wr_en;

	logic               q_push;
	logic               q_pop;
	dcrc_pkg::q_entry_t q_wdata;
	dcrc_pkg::q_entry_t q_rdata;
	dcrc_pkg::q_stat_t  q_stat;

	// Register decode uses paddr[3] only: 0x0 mode, 0x8 seed.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == REG_SEED) ? seed_value_q : {63'h0, crc_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_mode_q   <= dcrc_pkg::MODE_CRC32;
			seed_value_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3])
				REG_MODE: crc_mode_q   <= pwdata[0];
				REG_SEED: seed_value_q <= pwdata;
				default:  seed_value_q <= seed_value_q;
			endcase
		end
	end

	// front: count saturation, byte alignment, data term
	dcrc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_low      (data_low),
		.data_high     (data_high),
		.byte_count    (byte_count),
		.start_message (start_message),
		.crc_mode      (crc_mode_q),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	// decoupling queue between front and back
	dcrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// back: register update and result register
	dcrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.crc_mode   (crc_mode_q),
		.seed_value (seed_value_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crc_value  (crc_value)
	);

endmodule

`default_nettype wire

[sv/dcrc_checker.sv]
`default_nettype none

module dcrc_checker #(
	parameter int CAP = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [63:0] crc_value,
	input  wire logic        psel,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] prdata
);

	localparam int FLY_W = $clog2(CAP + 2);

	logic [FLY_W-1:0] inflight_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			unique case ({in_xfer, out_xfer})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_value))
		else $error("result changed while stalled");

	// no result without an input transfer behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result without a pending input transfer");

	// in_stall must rise before the internal storage overflows
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= FLY_W'(CAP))
		else $error("more transfers in flight than storage holds");

	// mode register reads back a single bit
	a_mode_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && !paddr[3] |-> prdata[63:1] == '0)
		else $error("mode register read shows stray bits");

endmodule

bind dual_crc32_crc64_engine dcrc_checker #(
	.CAP (QUEUE_DEPTH + 3)
) u_dcrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.crc_value (crc_value),
	.psel      (psel),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.prdata    (prdata)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

	// ---------------------------------------------------------------------
	// Timing constants
	// ---------------------------------------------------------------------
	localparam int CLK_HALF_NS    = 4;     // 8 ns period
	localparam int RESET_CYCLES   = 7;
	localparam int PIPE_LAT       = 3;     // settling margin used when draining the pipeline
	localparam int MAX_GAP        = 11;    // longest idle / stall drawn per transfer
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either channel
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_ITEMS    = 200;
	localparam int MAX_REPORTS    = 10;

	// register map: 64-bit seed forces 8-byte spacing
	localparam logic [3:0] REG_MODE_ADDR = 4'h0;
	localparam logic [3:0] REG_SEED_ADDR = 4'h8;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LOW_WORD = 64'h0000_0000_FFFF_FFFF;

	// ---------------------------------------------------------------------
	// DUT signals
	// ---------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] data_low;
	logic [63:0] data_high;
	logic [4:0]  byte_count;
	logic        start_message;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] crc_value;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	dual_crc32_crc64_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_low     (data_low),
		.data_high    (data_high),
		.byte_count   (byte_count),
		.start_message(start_message),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.crc_value    (crc_value),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// ---------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------
	initial clk = 1'b0;
	always #(CLK_HALF_NS) clk = ~clk;

	// ---------------------------------------------------------------------
	// CRC predictor state: our own copy of the mode, seed and raw register
	// ---------------------------------------------------------------------
	logic        crc_mode_shadow;
	logic [63:0] seed_shadow;
	logic [63:0] raw_crc;       // inverted register, as held inside the engine

	logic [63:0] crc_expect_q[$];   // finalized CRCs awaiting their output transfer

	int  mismatch_cnt;
	int  in_xfer_cnt;
	int  out_xfer_cnt;
	int  config_cnt;
	int  idle_cycles;
	bit  gaps_on;               // both sides draw random idles/stalls when set

	// One input transfer: optional reload from the inverted seed, then the valid
	// bytes folded in lowest first, a bit at a time. Returns the finalized CRC.
	function automatic logic [63:0] crc_advance(input logic [63:0] lo, input logic [63:0] hi,
						    input logic [4:0] cnt, input logic st);
		logic [63:0] r;
		logic [63:0] poly;
		logic [7:0]  b;
		int          n;
		poly = (crc_mode_shadow == dcrc_pkg::MODE_CRC64) ? dcrc_pkg::POLY64
								 : dcrc_pkg::POLY32;
		// count saturates at the lane width
		n = (cnt > dcrc_pkg::LANE_BYTES) ? dcrc_pkg::LANE_BYTES : int'(cnt);
		r = st ? ~seed_shadow : raw_crc;
		if (crc_mode_shadow == dcrc_pkg::MODE_CRC32)
			r = r & LOW_WORD;   // CRC-32 keeps only the low word, also on a mode switch
		for (int i = 0; i < n; i++) begin
			b = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
			r[7:0] = r[7:0] ^ b;
			for (int k = 0; k < 8; k++)
				r = (r >> 1) ^ (r[0] ? poly : 64'h0);
		end
		raw_crc = r;
		return (crc_mode_shadow == dcrc_pkg::MODE_CRC64) ? ~r : (~r & LOW_WORD);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
				       input logic [63:0] act_v);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("[%0t] %s: expected %h, got %h", $time, what, exp_v, act_v);
	endtask

	// ---------------------------------------------------------------------
	// APB access: setup cycle, then access cycle; completes on pready
	// ---------------------------------------------------------------------
	task automatic apb_write(input logic [3:0] addr, input logic [63:0] wdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_read(input logic [3:0] addr, output logic [63:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Write both registers, mirror them in the predictor and read them back.
	task automatic set_config(input logic mode, input logic [63:0] seed);
		logic [63:0] rd;
		apb_write(REG_MODE_ADDR, {63'h0, mode});
		apb_write(REG_SEED_ADDR, seed);
		crc_mode_shadow = mode;
		seed_shadow = seed;
		config_cnt++;
		apb_read(REG_MODE_ADDR, rd);
		if (rd !== {63'h0, mode})
			report_mismatch("crc_mode readback", {63'h0, mode}, rd);
		apb_read(REG_SEED_ADDR, rd);
		if (rd !== seed)
			report_mismatch("seed_value readback", seed, rd);
	endtask

	// Drop valid and let every outstanding result come back before touching
	// the registers, then add a settling margin.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid = 1'b0;
		while (crc_expect_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Input side: optional idle gap, then present the transfer and hold it
	// until accepted. Valid stays high on return so back-to-back transfers
	// never drop it.
	// ---------------------------------------------------------------------
	task automatic send_chunk(input logic [63:0] lo, input logic [63:0] hi,
				  input logic [4:0] cnt, input logic st);
		int gap;
		gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		data_low = lo;
		data_high = hi;
		byte_count = cnt;
		start_message = st;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		crc_expect_q.push_back(crc_advance(lo, hi, cnt, st));
		in_xfer_cnt++;
	endtask

	// ---------------------------------------------------------------------
	// Output side: random stall per result, released until the next transfer
	// ---------------------------------------------------------------------
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			n = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Result checker: every output transfer against the oldest expectation.
	always @(posedge clk) begin
		logic [63:0] exp_crc;
		if (arst_n && out_valid && !out_stall) begin
			out_xfer_cnt++;
			if (crc_expect_q.size() == 0) begin
				report_mismatch("unexpected result, none pending", 64'h0, crc_value);
			end else begin
				exp_crc = crc_expect_q.pop_front();
				if (crc_value !== exp_crc)
					report_mismatch("crc_value", exp_crc, crc_value);
			end
		end
	end

	// Watchdog: counts cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: %0d cycles with no transfer, %0d results pending",
				 idle_cycles, crc_expect_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset state: CRC-32, seed zero, register all ones; no start yet.
	task automatic test_reset_state();
		send_chunk(64'h0, 64'h0, 5'd0, 1'b0);
		send_chunk(64'h0000_0000_3433_3231, 64'h0, 5'd4, 1'b0);
		send_chunk(64'h0, 64'h0, 5'd0, 1'b1);
	endtask

	// CRC-32: check string, full lane, saturated counts, and a seed whose upper
	// word must be ignored.
	task automatic test_crc32_directed();
		drain_pipeline();
		set_config(dcrc_pkg::MODE_CRC32, 64'h0);
		send_chunk(64'h3837_3635_3433_3231, 64'h39, 5'd9, 1'b1);
		send_chunk(ALL_ONES, ALL_ONES, 5'd16, 1'b0);
		send_chunk(ALL_ONES, ALL_ONES, 5'd31, 1'b0);
		send_chunk(64'h0, 64'h0, 5'd17, 1'b0);
		send_chunk(64'h0, 64'h0, 5'd1, 1'b1);
		drain_pipeline();
		set_config(dcrc_pkg::MODE_CRC32, ALL_ONES);
		send_chunk(64'h0123_4567_89AB_CDEF, ALL_ONES, 5'd8, 1'b1);
		send_chunk(ALL_ONES, 64'h0, 5'd0, 1'b1);
	endtask

	// CRC-64: check string, extremes of data and seed, zero count on start.
	task automatic test_crc64_directed();
		drain_pipeline();
		set_config(dcrc_pkg::MODE_CRC64, 64'h0);
		send_chunk(64'h3837_3635_3433_3231, 64'h39, 5'd9, 1'b1);
		send_chunk(ALL_ONES, ALL_ONES, 5'd16, 1'b0);
		send_chunk(ALL_ONES, ALL_ONES, 5'd31, 1'b0);
		drain_pipeline();
		set_config(dcrc_pkg::MODE_CRC64, ALL_ONES);
		send_chunk(64'h0, 64'h0, 5'd0, 1'b1);
		send_chunk(64'h55AA_55AA_55AA_55AA, 64'hAA55_AA55_AA55_AA55, 5'd16, 1'b1);
	endtask

	// Mode switch mid-message: the raw register carries over, truncated to
	// its low word when going to CRC-32.
	task automatic test_mode_switch();
		drain_pipeline();
		set_config(dcrc_pkg::MODE_CRC64, 64'h0123_4567_89AB_CDEF);
		send_chunk(64'hDEAD_BEEF_CAFE_F00D, 64'h0, 5'd5, 1'b1);
		drain_pipeline();
		set_config(dcrc_pkg::MODE_CRC32, 64'h0123_4567_89AB_CDEF);
		send_chunk(64'h1122_3344_5566_7788, 64'h0, 5'd7, 1'b0);
		drain_pipeline();
		set_config(dcrc_pkg::MODE_CRC64, 64'h0);
		send_chunk(64'h00FF_00FF_00FF_00FF, 64'h0, 5'd3, 1'b0);
		send_chunk(64'h0, 64'h0, 5'd0, 1'b0);
	endtask

	// Random messages of random length under several register settings.
	// Mostly well-formed (start on the first transfer of each message), with
	// an occasional stray or missing start; counts mostly in range, some above.
	task automatic test_random_stream();
		logic [63:0] seed;
		logic        mode;
		logic [4:0]  cnt;
		logic        st;
		int          msg_left;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			drain_pipeline();
			case (phase % 4)
				0: seed = 64'h0;
				1: seed = ALL_ONES;
				default: seed = {$urandom, $urandom};
			endcase
			mode = (phase < 4) ? phase[0] : logic'($urandom_range(0, 1));
			set_config(mode, seed);
			msg_left = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 50 == 0)
					gaps_on = ($urandom_range(0, 3) != 0);
				if (msg_left == 0) begin
					msg_left = $urandom_range(1, 12);
					st = 1'b1;
				end else begin
					st = 1'b0;
				end
				msg_left--;
				if ($urandom_range(0, 15) == 0)
					st = logic'($urandom_range(0, 1));
				cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
								  : 5'($urandom_range(0, 16));
				send_chunk({$urandom, $urandom}, {$urandom, $urandom}, cnt, st);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		crc_mode_shadow = dcrc_pkg::MODE_CRC32;
		seed_shadow = 64'h0;
		raw_crc = ALL_ONES;
		mismatch_cnt = 0;
		in_xfer_cnt = 0;
		out_xfer_cnt = 0;
		config_cnt = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_low = 64'h0;
		data_high = 64'h0;
		byte_count = 5'd0;
		start_message = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'h0;
		pwdata = 64'h0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_crc32_directed();
		test_crc64_directed();
		test_mode_switch();
		test_random_stream();

		// wait for the last results, then a little slack for stray outputs
		drain_pipeline();
		repeat (2 * PIPE_LAT) @(posedge clk);

		$display("Covered %0d input transfers and %0d results across %0d register settings",
			 in_xfer_cnt, out_xfer_cnt, config_cnt);
		$display("in both CRC-32 and CRC-64 modes, with random idles and stalls");
		if (mismatch_cnt == 0 && crc_expect_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Errors: %0d, results never seen: %0d", mismatch_cnt, crc_expect_q.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
